/* rtl/mmbp_pkg.sv */
// ----------------------------------------------------------------------------
// mmbp_pkg
// shared types, register map, reset values and a counter helper for the
// multi-mode branch predictor
// ----------------------------------------------------------------------------
package mmbp_pkg;

    // default table geometry
    localparam int GLOBAL_HISTORY_MAX_DEF = 13;
    localparam int LOCAL_HISTORY_MAX_DEF  = 11;
    localparam int PC_INDEX_MAX_DEF       = 11;

    // fixed widths of the custom hybrid mode
    localparam int CUSTOM_GLOBAL_BITS = 13;
    localparam int CUSTOM_LOCAL_BITS  = 11;
    localparam int CUSTOM_PC_BITS     = 11;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_STATIC = 2'd0,
        MODE_GSHARE = 2'd1,
        MODE_TOURN  = 2'd2,
        MODE_CUSTOM = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_GHIST_W  = 2'd1,
        REG_LHIST_W  = 2'd2,
        REG_PCIDX_W  = 2'd3
    } t_reg;

    localparam t_mode      RST_MODE    = MODE_STATIC;
    localparam logic [3:0] RST_GHIST_W = 4'd13;
    localparam logic [3:0] RST_LHIST_W = 4'd11;
    localparam logic [3:0] RST_PCIDX_W = 4'd11;

    // 2-bit counter values
    localparam logic [1:0] CTR_MIN  = 2'd0;
    localparam logic [1:0] CTR_MAX  = 2'd3;
    localparam logic [1:0] CTR_WEAK = 2'd1;

    function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic taken);
        logic [1:0] r;
        if (taken) begin
            r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return r;
    endfunction

endpackage

/* rtl/multi_mode_branch_predictor_top.sv */
// ----------------------------------------------------------------------------
// multi_mode_branch_predictor_top
// a branch request accepted into stage 1 moves through stage 2 to the output
//   register that drives o_valid; one request per cycle is sustained while no
//   result stalls; a stalled result freezes the whole three-stage pipeline and input
// after reset a clearing pass loads every table entry with its reset value;
//   o_ready stays low meanwhile, config writes are taken
// ----------------------------------------------------------------------------
module multi_mode_branch_predictor_top #(
    parameter int GLOBAL_HISTORY_MAX = mmbp_pkg::GLOBAL_HISTORY_MAX_DEF,
    parameter int LOCAL_HISTORY_MAX  = mmbp_pkg::LOCAL_HISTORY_MAX_DEF,
    parameter int PC_INDEX_MAX       = mmbp_pkg::PC_INDEX_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // branch request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [31:0]                     i_pc,
    input  logic                            i_outcome,
    // prediction channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_prediction,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mmbp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mmbp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mmbp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import mmbp_pkg::*;

    localparam int GMAX = GLOBAL_HISTORY_MAX;
    localparam int LMAX = LOCAL_HISTORY_MAX;
    localparam int PMAX = PC_INDEX_MAX;
    localparam int CLR_W = (GMAX > LMAX) ? ((GMAX > PMAX) ? GMAX : PMAX)
                                          : ((LMAX > PMAX) ? LMAX : PMAX);

    localparam int CUST_G = (CUSTOM_GLOBAL_BITS < GMAX) ? CUSTOM_GLOBAL_BITS : GMAX;
    localparam int CUST_L = (CUSTOM_LOCAL_BITS < LMAX) ? CUSTOM_LOCAL_BITS : LMAX;
    localparam int CUST_P = (CUSTOM_PC_BITS < PMAX) ? CUSTOM_PC_BITS : PMAX;
    localparam logic [GMAX-1:0] CG_MASK = GMAX'((64'd1 << CUST_G) - 64'd1);
    localparam logic [LMAX-1:0] CL_MASK = LMAX'((64'd1 << CUST_L) - 64'd1);
    localparam logic [PMAX-1:0] CP_MASK = PMAX'((64'd1 << CUST_P) - 64'd1);

    typedef struct packed {
        logic            vld_g;  // global counter written
        logic            vld_t;  // choice and local counter written
        logic [GMAX-1:0] gidx;
        logic [LMAX-1:0] lidx;
        logic [1:0]      gc;
        logic [1:0]      ch;
        logic [1:0]      lc;
    } t_wrec;

    // configuration
    t_mode      r_mode;
    logic [3:0] r_ghb;
    logic [3:0] r_lhb;
    logic [3:0] r_pib;

    // tables
    logic [1:0]      r_gc_mem [2**GMAX];
    logic [1:0]      r_ch_mem [2**GMAX];
    logic [LMAX-1:0] r_lh_mem [2**PMAX];
    logic [1:0]      r_lc_mem [2**LMAX];

    logic             r_clr_busy;
    logic [CLR_W-1:0] r_clr;

    logic [GMAX-1:0] r_ghist;

    // stage 1
    logic            r_s1_vld;
    logic            r_s1_taken;
    logic [GMAX-1:0] r_s1_gidx;
    logic [PMAX-1:0] r_s1_pidx;
    logic [LMAX-1:0] r_lh_rd;
    logic [1:0]      r_gc_rd;
    logic [1:0]      r_ch_rd;

    // stage 2
    logic            r_s2_vld;
    logic            r_s2_taken;
    logic [GMAX-1:0] r_s2_gidx;
    logic [LMAX-1:0] r_s2_lidx;
    logic [1:0]      r_s2_gc_rd;
    logic [1:0]      r_s2_ch_rd;
    logic [1:0]      r_lc_rd;

    // recent writes, newest in r_wrec0
    t_wrec r_wrec0;
    t_wrec r_wrec1;
    logic            r_lw_vld;
    logic [PMAX-1:0] r_lw_addr;
    logic [LMAX-1:0] r_lw_data;

    logic r_out_vld;
    logic r_out_pred;

    logic            w_adv;
    logic            w_acc;
    logic            w_tourn;
    logic            w_cfg_wr;
    logic [GMAX-1:0] w_gmask;
    logic [LMAX-1:0] w_lmask;
    logic [PMAX-1:0] w_pmask;
    logic [GMAX-1:0] w_gidx_in;
    logic [PMAX-1:0] w_pidx_in;
    logic [LMAX-1:0] w_lh_cur;
    logic [LMAX-1:0] w_s1_lidx;
    logic [LMAX-1:0] n_lh;
    logic [1:0]      w_gc;
    logic [1:0]      w_ch;
    logic [1:0]      w_lc;
    logic            w_gres;
    logic            w_lres;
    logic            n_pred;
    logic [1:0]      n_gc;
    logic [1:0]      n_ch;
    logic [1:0]      n_lc;
    logic            w_s2_wr;
    logic            w_gc_we;
    logic            w_t_we;
    logic            w_lh_we;
    logic            w_lc_clr;
    logic            w_lh_clr;
    logic            w_g_clr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign w_adv   = !r_out_vld || i_ready;
    assign o_ready = w_adv && !r_clr_busy;
    assign w_acc   = i_valid && o_ready;
    assign w_tourn = (r_mode == MODE_TOURN) || (r_mode == MODE_CUSTOM);

    assign o_valid      = r_out_vld;
    assign o_prediction = r_out_pred;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= RST_MODE;
            r_ghb  <= RST_GHIST_W;
            r_lhb  <= RST_LHIST_W;
            r_pib  <= RST_PCIDX_W;
        end else if (w_cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_MODE:    r_mode <= t_mode'(pwdata[1:0]);
                REG_GHIST_W: r_ghb  <= pwdata[3:0];
                REG_LHIST_W: r_lhb  <= pwdata[3:0];
                REG_PCIDX_W: r_pib  <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_MODE:    prdata = {30'd0, r_mode};
            REG_GHIST_W: prdata = {28'd0, r_ghb};
            REG_LHIST_W: prdata = {28'd0, r_lhb};
            REG_PCIDX_W: prdata = {28'd0, r_pib};
        endcase
    end

    // index masks: bit i is kept when i is below the clamped width, or the fixed custom width
    always_comb begin
        for (int i = 0; i < GMAX; i++) begin
            w_gmask[i] = (i == 0) || ({28'd0, r_ghb} > 32'(i));
        end
        for (int i = 0; i < LMAX; i++) begin
            w_lmask[i] = (i == 0) || ({28'd0, r_lhb} > 32'(i));
        end
        for (int i = 0; i < PMAX; i++) begin
            w_pmask[i] = (i == 0) || ({28'd0, r_pib} > 32'(i));
        end
        if (r_mode == MODE_CUSTOM) begin
            w_gmask = CG_MASK;
            w_lmask = CL_MASK;
            w_pmask = CP_MASK;
        end
    end

    always_comb begin
        unique case (r_mode)
            MODE_STATIC: w_gidx_in = '0;
            MODE_GSHARE: w_gidx_in = (i_pc[GMAX-1:0] ^ r_ghist) & w_gmask;
            MODE_TOURN:  w_gidx_in = r_ghist & w_gmask;
            MODE_CUSTOM: w_gidx_in = (i_pc[GMAX-1:0] ^ r_ghist) & w_gmask;
        endcase
        w_pidx_in = i_pc[PMAX-1:0] & w_pmask;
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
        end else if (r_clr_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_g_clr  = r_clr_busy && ((r_clr >> GMAX) == '0);
    assign w_lh_clr = r_clr_busy && ((r_clr >> PMAX) == '0);
    assign w_lc_clr = r_clr_busy && ((r_clr >> LMAX) == '0);

    // stage 1: local history with forwarding of the last history write
    assign w_lh_cur  = (r_lw_vld && (r_lw_addr == r_s1_pidx)) ? r_lw_data : r_lh_rd;
    assign w_s1_lidx = w_lh_cur & w_lmask;
    assign n_lh      = ((w_s1_lidx << 1) | LMAX'(r_s1_taken)) & w_lmask;
    assign w_lh_we   = w_adv && r_s1_vld && w_tourn;

    // stage 2: counters with forwarding of the two most recent writes
    always_comb begin
        if (r_wrec0.vld_g && (r_wrec0.gidx == r_s2_gidx)) begin
            w_gc = r_wrec0.gc;
        end else if (r_wrec1.vld_g && (r_wrec1.gidx == r_s2_gidx)) begin
            w_gc = r_wrec1.gc;
        end else begin
            w_gc = r_s2_gc_rd;
        end
        if (r_wrec0.vld_t && (r_wrec0.gidx == r_s2_gidx)) begin
            w_ch = r_wrec0.ch;
        end else if (r_wrec1.vld_t && (r_wrec1.gidx == r_s2_gidx)) begin
            w_ch = r_wrec1.ch;
        end else begin
            w_ch = r_s2_ch_rd;
        end
        if (r_wrec0.vld_t && (r_wrec0.lidx == r_s2_lidx)) begin
            w_lc = r_wrec0.lc;
        end else if (r_wrec1.vld_t && (r_wrec1.lidx == r_s2_lidx)) begin
            w_lc = r_wrec1.lc;
        end else begin
            w_lc = r_lc_rd;
        end
    end

    assign w_gres = w_gc[1];
    assign w_lres = w_lc[1];
    assign n_gc   = ctr_train(w_gc, r_s2_taken);
    assign n_lc   = ctr_train(w_lc, r_s2_taken);

    always_comb begin
        unique case (r_mode)
            MODE_STATIC: n_pred = 1'b1;
            MODE_GSHARE: n_pred = w_gres;
            MODE_TOURN:  n_pred = w_ch[1] ? w_lres : w_gres;
            MODE_CUSTOM: n_pred = w_ch[1] ? w_lres : w_gres;
        endcase
        // choice moves toward whichever side alone was right
        priority if ((w_gres == r_s2_taken) && (w_lres != r_s2_taken) && (w_ch != CTR_MIN)) begin
            n_ch = w_ch - 2'd1;
        end else if ((w_gres != r_s2_taken) && (w_lres == r_s2_taken)
                     && (w_ch != CTR_MAX)) begin
            n_ch = w_ch + 2'd1;
        end else begin
            n_ch = w_ch;
        end
    end

    assign w_s2_wr = w_adv && r_s2_vld && (r_mode != MODE_STATIC);
    assign w_gc_we = w_s2_wr;
    assign w_t_we  = w_s2_wr && w_tourn;

    // table ports
    always_ff @(posedge i_clk) begin
        if (w_g_clr) begin
            r_gc_mem[r_clr[GMAX-1:0]] <= CTR_WEAK;
        end else if (w_gc_we) begin
            r_gc_mem[r_s2_gidx] <= n_gc;
        end
        if (w_adv) begin
            r_gc_rd <= r_gc_mem[w_gidx_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_g_clr) begin
            r_ch_mem[r_clr[GMAX-1:0]] <= CTR_WEAK;
        end else if (w_t_we) begin
            r_ch_mem[r_s2_gidx] <= n_ch;
        end
        if (w_adv) begin
            r_ch_rd <= r_ch_mem[w_gidx_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lh_clr) begin
            r_lh_mem[r_clr[PMAX-1:0]] <= '0;
        end else if (w_lh_we) begin
            r_lh_mem[r_s1_pidx] <= n_lh;
        end
        if (w_adv) begin
            r_lh_rd <= r_lh_mem[w_pidx_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lc_clr) begin
            r_lc_mem[r_clr[LMAX-1:0]] <= CTR_WEAK;
        end else if (w_t_we) begin
            r_lc_mem[r_s2_lidx] <= n_lc;
        end
        if (w_adv) begin
            r_lc_rd <= r_lc_mem[w_s1_lidx];
        end
    end

    // pipeline control and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ghist         <= '0;
            r_s1_vld        <= 1'b0;
            r_s2_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
            r_lw_vld        <= 1'b0;
            r_wrec0.vld_g   <= 1'b0;
            r_wrec0.vld_t   <= 1'b0;
            r_wrec1.vld_g   <= 1'b0;
            r_wrec1.vld_t   <= 1'b0;
        end else begin
            if (w_acc && (r_mode != MODE_STATIC)) begin
                r_ghist <= (r_ghist << 1) | GMAX'(i_outcome);
            end
            if (w_adv) begin
                r_s1_vld  <= w_acc;
                r_s2_vld  <= r_s1_vld;
                r_out_vld <= r_s2_vld;
            end
            if (w_lh_we) begin
                r_lw_vld <= 1'b1;
            end
            if (w_s2_wr) begin
                r_wrec1       <= r_wrec0;
                r_wrec0.vld_g <= 1'b1;
                r_wrec0.vld_t <= w_tourn;
                r_wrec0.gidx  <= r_s2_gidx;
                r_wrec0.lidx  <= r_s2_lidx;
                r_wrec0.gc    <= n_gc;
                r_wrec0.ch    <= n_ch;
                r_wrec0.lc    <= n_lc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_taken <= i_outcome;
            r_s1_gidx  <= w_gidx_in;
            r_s1_pidx  <= w_pidx_in;
            r_s2_taken <= r_s1_taken;
            r_s2_gidx  <= r_s1_gidx;
            r_s2_lidx  <= w_s1_lidx;
            r_s2_gc_rd <= r_gc_rd;
            r_s2_ch_rd <= r_ch_rd;
            r_out_pred <= n_pred;
        end
        if (w_lh_we) begin
            r_lw_addr <= r_s1_pidx;
            r_lw_data <= n_lh;
        end
    end

    a_clr_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("branch request taken during table clear");

    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_vld && !r_s2_vld && !r_out_vld && !r_lw_vld))
        else $error("pipeline busy during table clear");

    a_static_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s2_vld && (r_mode == MODE_STATIC)) |=> (o_valid && o_prediction))
        else $error("static mode predicted not taken");

    a_ghist_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_mode != MODE_STATIC)) |=> (r_ghist[0] == $past(i_outcome)))
        else $error("global history missed the branch outcome");

endmodule

/* verif/multi_mode_branch_predictor_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_mode_branch_predictor_top_tb
// self-checking bench for the multi-mode branch predictor: a directed table
// walks all four modes, the width extremes and counter saturation, then
// random phases replay patterned branch streams under random idling; every
// prediction is checked against a given value or a cycle-free model of the tables
// ----------------------------------------------------------------------------
module multi_mode_branch_predictor_top_tb;
    import mmbp_pkg::*;

    localparam int GH_MAX = GLOBAL_HISTORY_MAX_DEF;
    localparam int LH_MAX = LOCAL_HISTORY_MAX_DEF;
    localparam int PC_MAX = PC_INDEX_MAX_DEF;
    localparam int POOL_N = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 118;

    typedef enum logic {
        ROW_BRANCH,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        t_reg       cfg_reg;
        logic [3:0] value;
        logic [31:0] pc;
        logic       outcome;
        logic       known;
        logic       pred;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [31:0]            i_pc = '0;
    logic                   i_outcome = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_prediction;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // register mirror
    t_mode      cfg_mode = RST_MODE;
    logic [3:0] cfg_ghist_w = RST_GHIST_W;
    logic [3:0] cfg_lhist_w = RST_LHIST_W;
    logic [3:0] cfg_pcidx_w = RST_PCIDX_W;

    // table mirror
    logic [GH_MAX-1:0] ghist_m;
    logic [1:0]        gctr_m [1 << GH_MAX];
    logic [1:0]        chc_m  [1 << GH_MAX];
    logic [LH_MAX-1:0] lhist_m[1 << PC_MAX];
    logic [1:0]        lctr_m [1 << LH_MAX];

    logic pred_expect_q[$];
    int   err_cnt = 0;
    bit   calm = 1'b0;

    t_row        dir_rows[$];
    logic [31:0] pool_pc [POOL_N];
    logic [7:0]  pool_pat[POOL_N];
    int          pool_len[POOL_N];
    int          pool_pos[POOL_N];

    multi_mode_branch_predictor_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pc         (i_pc),
        .i_outcome    (i_outcome),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_prediction (o_prediction),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned fit_width(input int unsigned w, input int unsigned maxw);
        if (w < 1) begin
            return 1;
        end
        return (w > maxw) ? maxw : w;
    endfunction

    function automatic logic [1:0] bump_ctr(input logic [1:0] c, input logic taken);
        if (taken) begin
            return (c == 2'd3) ? c : c + 2'd1;
        end
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // prediction before training, then train the mirror tables
    function automatic logic predict_branch(input logic [31:0] pc, input logic taken);
        int unsigned gmask, lmask, pmask, gidx, lidx, pidx, hist;
        logic [1:0] ch, gc, lc;
        logic gdir, ldir, dir;
        dir = 1'b1;
        hist = 32'(ghist_m);
        case (cfg_mode)
            MODE_GSHARE: begin
                gmask = (32'd1 << fit_width(32'(cfg_ghist_w), GH_MAX)) - 1;
                gidx = (pc ^ hist) & gmask;
                dir = gctr_m[gidx][1];
                gctr_m[gidx] = bump_ctr(gctr_m[gidx], taken);
                ghist_m = {ghist_m[GH_MAX-2:0], taken};
            end
            MODE_TOURN, MODE_CUSTOM: begin
                if (cfg_mode == MODE_TOURN) begin
                    gmask = (32'd1 << fit_width(32'(cfg_ghist_w), GH_MAX)) - 1;
                    lmask = (32'd1 << fit_width(32'(cfg_lhist_w), LH_MAX)) - 1;
                    pmask = (32'd1 << fit_width(32'(cfg_pcidx_w), PC_MAX)) - 1;
                    gidx = hist & gmask;
                end else begin
                    gmask = (32'd1 << fit_width(CUSTOM_GLOBAL_BITS, GH_MAX)) - 1;
                    lmask = (32'd1 << fit_width(CUSTOM_LOCAL_BITS, LH_MAX)) - 1;
                    pmask = (32'd1 << fit_width(CUSTOM_PC_BITS, PC_MAX)) - 1;
                    gidx = (pc ^ hist) & gmask;
                end
                pidx = pc & pmask;
                lidx = 32'(lhist_m[pidx]) & lmask;
                ch = chc_m[gidx];
                gc = gctr_m[gidx];
                lc = lctr_m[lidx];
                gdir = gc[1];
                ldir = lc[1];
                dir = ch[1] ? ldir : gdir;
                // choice leans toward whichever side alone was right
                if (gdir == taken && ldir != taken && ch != 2'd0) begin
                    ch = ch - 2'd1;
                end else if (gdir != taken && ldir == taken && ch != 2'd3) begin
                    ch = ch + 2'd1;
                end
                chc_m[gidx] = ch;
                gctr_m[gidx] = bump_ctr(gc, taken);
                lctr_m[lidx] = bump_ctr(lc, taken);
                ghist_m = {ghist_m[GH_MAX-2:0], taken};
                lhist_m[pidx] = LH_MAX'(((lidx << 1) | 32'(taken)) & lmask);
            end
            default: begin
            end
        endcase
        return dir;
    endfunction

    function automatic t_row br(input logic [31:0] pc, input logic outcome,
                                input logic known = 1'b0, input logic pred = 1'b0);
        t_row r;
        r = '0;
        r.kind = ROW_BRANCH;
        r.pc = pc;
        r.outcome = outcome;
        r.known = known;
        r.pred = pred;
        return r;
    endfunction

    function automatic t_row wr(input t_reg cfg_reg, input logic [3:0] value);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.cfg_reg = cfg_reg;
        r.value = value;
        return r;
    endfunction

    // called at a falling edge, returns at a fresh falling edge
    task automatic send_branch(input logic [31:0] pc, input logic outcome,
                               input logic known, input logic pred);
        logic model_pred;
        if (!calm) begin
            while ($urandom_range(99) < 16) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_pc <= pc;
        i_outcome <= outcome;
        do @(posedge i_clk); while (!o_ready);
        model_pred = predict_branch(pc, outcome);
        pred_expect_q.push_back(known ? pred : model_pred);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pred_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg cfg_reg, input logic [3:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({cfg_reg, 2'b00});
        pwdata <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (cfg_reg)
            REG_MODE:    cfg_mode = t_mode'(value[1:0]);
            REG_GHIST_W: cfg_ghist_w = value;
            REG_LHIST_W: cfg_lhist_w = value;
            default:     cfg_pcidx_w = value;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic reseed_pool;
        for (int k = 0; k < POOL_N; k++) begin
            pool_pc[k] = $urandom;
            pool_pat[k] = 8'($urandom);
            pool_len[k] = $urandom_range(8, 1);
            pool_pos[k] = 0;
        end
    endtask

    always @(negedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin : check_prediction
        logic want_pred;
        if (i_rst_n && o_valid && i_ready) begin
            if (pred_expect_q.size() == 0) begin
                $error("prediction: unexpected result, actual %0b", o_prediction);
                err_cnt++;
            end else begin
                want_pred = pred_expect_q.pop_front();
                if (o_prediction !== want_pred) begin
                    $error("prediction mismatch: expected %0b, actual %0b",
                           want_pred, o_prediction);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row  r;
        t_mode phase_mode[PHASES];
        logic [31:0] pc;
        logic outcome;
        int k;

        ghist_m = '0;
        for (int n = 0; n < (1 << GH_MAX); n++) begin
            gctr_m[n] = 2'd1;
            chc_m[n] = 2'd1;
        end
        for (int n = 0; n < (1 << PC_MAX); n++) begin
            lhist_m[n] = '0;
        end
        for (int n = 0; n < (1 << LH_MAX); n++) begin
            lctr_m[n] = 2'd1;
        end

        // static mode after reset always says taken
        dir_rows.push_back(br(32'h0000_0000, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(br(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
        dir_rows.push_back(br(32'h1234_5678, 1'b0, 1'b1, 1'b1));
        dir_rows.push_back(wr(REG_MODE, 4'(MODE_GSHARE)));
        // untouched counter is weakly not taken
        dir_rows.push_back(br(32'h0000_0000, 1'b1, 1'b1, 1'b0));
        dir_rows.push_back(br(32'hFFFF_FFFF, 1'b1));
        for (int n = 0; n < 4; n++) begin
            dir_rows.push_back(br(32'h0000_0040, 1'b1));
        end
        // width below range clamps to one bit, above range to the maximum
        dir_rows.push_back(wr(REG_GHIST_W, 4'd0));
        dir_rows.push_back(br(32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(wr(REG_GHIST_W, 4'd15));
        dir_rows.push_back(br(32'hAAAA_AAAA, 1'b1));
        dir_rows.push_back(wr(REG_MODE, 4'(MODE_TOURN)));
        dir_rows.push_back(wr(REG_LHIST_W, 4'd0));
        dir_rows.push_back(wr(REG_PCIDX_W, 4'd15));
        for (int n = 0; n < 3; n++) begin
            dir_rows.push_back(br(32'h0000_0100, 1'b1));
        end
        // local histories survive the width change, masked on use
        dir_rows.push_back(wr(REG_LHIST_W, 4'd15));
        dir_rows.push_back(wr(REG_PCIDX_W, 4'd0));
        dir_rows.push_back(br(32'h0000_0100, 1'b0));
        dir_rows.push_back(wr(REG_MODE, 4'(MODE_CUSTOM)));
        dir_rows.push_back(br(32'h0000_5555, 1'b1));
        dir_rows.push_back(br(32'h0000_5555, 1'b0));
        dir_rows.push_back(br(32'h0000_5555, 1'b1));
        dir_rows.push_back(wr(REG_MODE, 4'(MODE_STATIC)));
        dir_rows.push_back(br(32'h0000_5555, 1'b0, 1'b1, 1'b1));

        phase_mode = '{MODE_GSHARE, MODE_TOURN, MODE_CUSTOM, MODE_TOURN,
                       MODE_GSHARE, MODE_STATIC, MODE_TOURN, MODE_CUSTOM};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            r = dir_rows[n];
            if (r.kind == ROW_WRITE) begin
                drain();
                write_reg(r.cfg_reg, r.value);
            end else begin
                send_branch(r.pc, r.outcome, r.known, r.pred);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(REG_MODE, 4'(phase_mode[p]));
            if (p == 1) begin
                write_reg(REG_GHIST_W, 4'd1);
                write_reg(REG_LHIST_W, 4'd1);
                write_reg(REG_PCIDX_W, 4'd1);
            end else if (p == 3) begin
                write_reg(REG_GHIST_W, 4'(GH_MAX));
                write_reg(REG_LHIST_W, 4'(LH_MAX));
                write_reg(REG_PCIDX_W, 4'(PC_MAX));
            end else begin
                write_reg(REG_GHIST_W, 4'($urandom_range(15)));
                write_reg(REG_LHIST_W, 4'($urandom_range(15)));
                write_reg(REG_PCIDX_W, 4'($urandom_range(15)));
            end
            reseed_pool();
            // one phase runs back to back on both sides
            calm = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 15) begin
                    pc = $urandom;
                    outcome = 1'($urandom_range(1));
                end else begin
                    // repeating per-branch patterns so the tables learn
                    k = $urandom_range(POOL_N - 1);
                    pc = pool_pc[k];
                    outcome = pool_pat[k][pool_pos[k]];
                    pool_pos[k] = (pool_pos[k] + 1) % pool_len[k];
                    if ($urandom_range(99) < 8) begin
                        outcome = ~outcome;
                    end
                end
                send_branch(pc, outcome, 1'b0, 1'b0);
            end
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pred_expect_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
